@@ src/catmull_rom_curve_sampler_top_defines.svh @@
// Assertion macros for the Catmull-Rom curve sampler checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CATMULL_ROM_CURVE_SAMPLER_TOP_DEFINES_SVH
`define CATMULL_ROM_CURVE_SAMPLER_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define CRCS_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("curve sampler check failed");

// Condition holds in the cycle after the trigger.
`define CRCS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("curve sampler check failed");

`endif

@@ src/crcs_pkg.sv @@
// Shared types and constants of the Catmull-Rom curve sampler.
// No dependencies; used by the top level and its checker.
package crcs_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned IDX_BITS    = 13;
  localparam int unsigned LEN_BITS    = 13;

  // Horner accumulator: the cubic coefficient sums stay below 24 full-scale samples.
  localparam int unsigned H_BITS    = SAMPLE_BITS + 6;
  localparam int unsigned PROD_BITS = H_BITS + FRAC_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [H_BITS-1:0]      horner_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

@@ src/catmull_rom_curve_sampler_top.sv @@
// Catmull-Rom curve sampler: sample table in a single-port RAM plus a Horner sequencer.
// Depends on crcs_pkg.
//
// A write request stores one sample and gives no result. A query
// request reads its neighbor samples from the table one per cycle over the single
// RAM port, then evaluates the interpolant on one shared multiplier, each Horner
// step a multiply state (S_MUL) and then an add state (S_ADD). An empty table reads
// no sample, a query that clamps to an end sample reads one, one in the first or
// last interval (linear) reads two and one in an inner interval (cubic) reads four.
// The next request is taken while the last result still waits.
// Table contents are undefined until written; there is no clearing pass.
module catmull_rom_curve_sampler_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [crcs_pkg::ADDR_BITS-1:0]       sample_addr_i,
  input  crcs_pkg::sample_t                    sample_value_i,
  input  logic signed [crcs_pkg::IDX_BITS-1:0] index_int_i,
  input  logic [crcs_pkg::FRAC_BITS-1:0]       index_frac_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output crcs_pkg::sample_t                    interp_value_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [crcs_pkg::LEN_BITS-1:0]        cfg_data_i
);
  import crcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_COEF = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_LIN  = 2'd2;
  localparam logic [1:0] MODE_CUB  = 2'd3;

  localparam int unsigned CMP_BITS = LEN_BITS + 1;
  localparam int unsigned HP1_BITS = H_BITS + 1;
  localparam int          HALF     = 2 ** (FRAC_BITS - 1);
  localparam int          SMAX     = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int          SMIN     = -SMAX - 1;

  logic [2:0]                state_q, state_d;
  logic [LEN_BITS-1:0]       len_q;
  logic [1:0]                mode_q, mode_d;
  logic [FRAC_BITS-1:0]      f_q;
  logic [ADDR_BITS-1:0]      rd_addr_q, base_d;
  logic [2:0]                rd_left_q, nrd_d;
  logic                      rd_vld_q;
  logic [SAMPLE_BITS-1:0]    rd_data_q;
  sample_t                   p_q [4];
  horner_t                   h_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic [1:0]                step_q;
  logic                      out_valid_q;
  sample_t                   out_q;

  logic [SAMPLE_BITS-1:0]    curve_store_q [TABLE_DEPTH];

  logic                      in_acc, mem_we, mem_re, out_free;
  logic [LEN_BITS-1:0]       n_clamp;
  logic signed [CMP_BITS-1:0] n_s, i_s, nm1, nm2;
  horner_t                   q0, q1, q2, q3, c0, c1, c2, c3, lin_d, addend, h_next;
  horner_t                   h_half, res_pre, init_h;
  logic signed [PROD_BITS-1:0] prod_d, prod_rnd;
  sample_t                   res_sat;
  logic [1:0]                init_step;

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_acc         = in_valid_i && !in_stall_o;
  assign mem_we         = in_acc && (req_type_i == REQ_WRITE);
  assign mem_re         = (state_q == S_READ);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_q;
  assign out_free       = !out_valid_q || !out_stall_i;

  // Classify the query: empty, clamped end sample, linear edge interval or cubic.
  always_comb begin
    n_clamp = (len_q > LEN_BITS'(TABLE_DEPTH)) ? LEN_BITS'(TABLE_DEPTH) : len_q;
    n_s     = $signed({1'b0, n_clamp});
    i_s     = CMP_BITS'(index_int_i);
    nm1     = n_s - CMP_BITS'(1);
    nm2     = n_s - CMP_BITS'(2);
    mode_d  = MODE_CUB;
    base_d  = ADDR_BITS'(i_s - CMP_BITS'(1));
    nrd_d   = 3'd4;
    if (n_clamp == '0) begin
      mode_d = MODE_ZERO;
      base_d = '0;
      nrd_d  = 3'd0;
    end else if (i_s < 0) begin
      mode_d = MODE_ONE;
      base_d = '0;
      nrd_d  = 3'd1;
    end else if (i_s >= nm1) begin
      mode_d = MODE_ONE;
      base_d = ADDR_BITS'(nm1);
      nrd_d  = 3'd1;
    end else if (i_s < CMP_BITS'(1) || i_s >= nm2) begin
      mode_d = MODE_LIN;
      base_d = ADDR_BITS'(i_s);
      nrd_d  = 3'd2;
    end
  end

  // Coefficients from the four samples; p_q[3] holds the last one read.
  always_comb begin
    q0     = H_BITS'(p_q[0]);
    q1     = H_BITS'(p_q[1]);
    q2     = H_BITS'(p_q[2]);
    q3     = H_BITS'(p_q[3]);
    c0     = q1 <<< 1;
    c1     = q2 - q0;
    c2     = (q0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - q3;
    c3     = ((q1 <<< 1) + q1) - ((q2 <<< 1) + q2) + q3 - q0;
    lin_d  = q3 - q2;
    case (mode_q)
      MODE_CUB: begin
        init_h    = c3;
        init_step = 2'd3;
      end
      MODE_LIN: begin
        init_h    = lin_d;
        init_step = 2'd1;
      end
      MODE_ONE: begin
        init_h    = q3;
        init_step = 2'd0;
      end
      default: begin
        init_h    = '0;
        init_step = 2'd0;
      end
    endcase
    case (step_q)
      2'd3:    addend = c2;
      2'd2:    addend = c1;
      default: addend = (mode_q == MODE_CUB) ? c0 : q2;
    endcase
  end

  // Horner step: multiply, then round to nearest and add the next coefficient.
  always_comb begin
    prod_d   = PROD_BITS'(h_q) * PROD_BITS'($signed({1'b0, f_q}));
    prod_rnd = prod_q + PROD_BITS'(HALF);
    h_next   = addend + H_BITS'(prod_rnd >>> FRAC_BITS);
    h_half   = H_BITS'((HP1_BITS'(h_q) + HP1_BITS'(1)) >>> 1);
    res_pre  = (mode_q == MODE_CUB) ? h_half : h_q;
    if (res_pre > H_BITS'(SMAX)) begin
      res_sat = SAMPLE_BITS'(SMAX);
    end else if (res_pre < H_BITS'(SMIN)) begin
      res_sat = SAMPLE_BITS'(SMIN);
    end else begin
      res_sat = SAMPLE_BITS'(res_pre);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && req_type_i == REQ_QUERY) begin
          state_d = (nrd_d == 3'd0) ? S_COEF : S_READ;
        end
      end
      S_READ:  state_d = (rd_left_q == 3'd1) ? S_WAIT : S_READ;
      S_WAIT:  state_d = S_COEF;
      S_COEF:  state_d = (init_step == 2'd0) ? S_FIN : S_MUL;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = (step_q == 2'd1) ? S_FIN : S_MUL;
      S_FIN:   state_d = out_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= mem_re;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q    <= mode_d;
      f_q       <= index_frac_i;
      rd_addr_q <= base_d;
      rd_left_q <= nrd_d;
    end else if (state_q == S_READ) begin
      rd_addr_q <= rd_addr_q + ADDR_BITS'(1);
      rd_left_q <= rd_left_q - 3'd1;
    end
    // Shift each sample in as it returns from the RAM.
    if (rd_vld_q) begin
      p_q[0] <= p_q[1];
      p_q[1] <= p_q[2];
      p_q[2] <= p_q[3];
      p_q[3] <= sample_t'(rd_data_q);
    end
    case (state_q)
      S_COEF: begin
        h_q    <= init_h;
        step_q <= init_step;
      end
      S_MUL: prod_q <= prod_d;
      S_ADD: begin
        h_q    <= h_next;
        step_q <= step_q - 2'd1;
      end
      default: ;
    endcase
    if (state_q == S_FIN && out_free) begin
      out_q <= res_sat;
    end
  end

  // Single-port sample table, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      curve_store_q[sample_addr_i] <= sample_value_i;
    end else if (mem_re) begin
      rd_data_q <= curve_store_q[rd_addr_q];
    end
  end

endmodule

@@ src/crcs_checker.sv @@
// Port-level checker for the Catmull-Rom curve sampler, bound to the top level.
// Depends on crcs_pkg and catmull_rom_curve_sampler_top_defines.svh.
`include "catmull_rom_curve_sampler_top_defines.svh"

module crcs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 req_type_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [crcs_pkg::SAMPLE_BITS-1:0]     interp_value_o
);
  import crcs_pkg::*;

  // A stored sample never blocks the next request.
  `CRCS_ASSERT_NEXT(a_write_keeps_ready, in_valid_i && !in_stall_o && req_type_i == REQ_WRITE, !in_stall_o)

  // A query holds off further requests while it is evaluated.
  `CRCS_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && req_type_i == REQ_QUERY, in_stall_o)

  // A new result only appears at the end of a query.
  `CRCS_ASSERT_NOW(a_result_from_query, $rose(out_valid_o), $past(in_stall_o))

  // Hold a stalled result.
  `CRCS_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o && $stable(interp_value_o))

endmodule

bind catmull_rom_curve_sampler_top crcs_checker u_crcs_checker (.*);
